@@ sv/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg : shared types for the bitmap page allocator
// request and response payloads, controller to datapath command and status
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGE_W = 20;
  localparam int CNT_W  = 9;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_NO_RUN = 2'd1,
    ST_BAD    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RD_ZERO = 2'd0,
    RD_SCAN = 2'd1,
    RD_QUO  = 2'd2,
    RD_RW   = 2'd3
  } rd_sel_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [PAGE_W-1:0] page_index;
    logic [CNT_W-1:0]  page_count;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [PAGE_W-1:0] first_page;
  } rsp_t;

  typedef struct packed {
    logic    load;
    logic    clr_wr;
    logic    scan_start;
    logic    scan_step;
    logic    free_range;
    logic    alloc_range;
    logic    div_start;
    logic    div_step;
    logic    rmw_init;
    logic    rmw_wr;
    logic    out_load;
    rd_sel_e rd_sel;
    status_e out_status;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_bad;
    logic req_free;
    logic scan_found;
    logic scan_last;
    logic div_last;
    logic rmw_last;
    logic out_ready;
  } ctl_sts_t;

endpackage

@@ sv/bpa_ram.sv @@
// ----------------------------------------------------------------------------
// bpa_ram : generic single write port, single read port ram
// read data registered, in the cycle after the address
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpa_ctrl : sequencing for the bitmap page allocator
// clearing pass, request check, word scan, word divide, read-modify-write
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bpa_pkg::ctl_sts_t sts_i,
  output bpa_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DIV_START,
    S_DIV,
    S_RMW_INIT,
    S_RMW_RD,
    S_RMW_WR,
    S_FINISH
  } state_e;

  state_e            state_q, state_d;
  bpa_pkg::status_e  res_q, res_d;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.rd_sel     = bpa_pkg::RD_ZERO;
    cmd_o.out_status = res_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.req_bad) begin
          res_d   = bpa_pkg::ST_BAD;
          state_d = S_FINISH;
        end else if (sts_i.req_free) begin
          cmd_o.free_range = 1'b1;
          state_d          = S_DIV_START;
        end else begin
          cmd_o.scan_start = 1'b1;
          cmd_o.rd_sel     = bpa_pkg::RD_ZERO;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.rd_sel    = bpa_pkg::RD_SCAN;
        if (sts_i.scan_found) begin
          cmd_o.alloc_range = 1'b1;
          state_d           = S_DIV_START;
        end else if (sts_i.scan_last) begin
          res_d   = bpa_pkg::ST_NO_RUN;
          state_d = S_FINISH;
        end
      end
      S_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_RMW_INIT;
        end
      end
      S_RMW_INIT: begin
        cmd_o.rmw_init = 1'b1;
        cmd_o.rd_sel   = bpa_pkg::RD_QUO;
        state_d        = S_RMW_WR;
      end
      S_RMW_RD: begin
        cmd_o.rd_sel = bpa_pkg::RD_RW;
        state_d      = S_RMW_WR;
      end
      S_RMW_WR: begin
        cmd_o.rmw_wr = 1'b1;
        if (sts_i.rmw_last) begin
          res_d   = bpa_pkg::ST_DONE;
          state_d = S_FINISH;
        end else begin
          state_d = S_RMW_RD;
        end
      end
      S_FINISH: begin
        if (sts_i.out_ready) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      res_q   <= bpa_pkg::ST_DONE;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_CHECK))
    else $error("request load did not lead to the check step");

  a_finish_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_ready)
    else $error("result loaded while previous result still held");

endmodule

@@ sv/bpa_dp.sv @@
// ----------------------------------------------------------------------------
// bpa_dp : datapath for the bitmap page allocator
// free map ram, word scan with run carry, word index from page offset, range masking
// ----------------------------------------------------------------------------
module bpa_dp #(
  parameter int MANAGED_PAGES      = 4096,
  parameter int WORD_BITS          = 32,
  parameter int FIRST_MANAGED_PAGE = 1024,
  parameter int MAX_RUN            = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpa_pkg::req_t     in_req_i,
  input  bpa_pkg::ctl_cmd_t cmd_i,
  output bpa_pkg::ctl_sts_t sts_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output bpa_pkg::rsp_t     out_rsp_o
);

  localparam int MAP_WORDS = (MANAGED_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int OW        = $clog2(MAP_WORDS * WORD_BITS + 1);
  localparam int BW        = $clog2(WORD_BITS);
  localparam int NW        = bpa_pkg::CNT_W;
  localparam int PW        = bpa_pkg::PAGE_W;
  localparam int MW        = OW + 1;
  localparam int SH        = OW + BW;
  localparam int PRW       = OW + MW;

  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [OW-1:0] WB_OW     = OW'(WORD_BITS);
  localparam logic [MW-1:0] RECIP     =
    MW'(((64'd1 << SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

  bpa_pkg::req_t    req_q;
  logic [NW-1:0]    carry_q, carry_d;
  logic [AW-1:0]    scan_q;
  logic [OW-1:0]    sbase_q;
  logic [OW-1:0]    lo_q, hi_q;
  logic [OW-1:0]    rem_q;
  logic [AW-1:0]    quo_q;
  logic [AW-1:0]    rw_word_q;
  logic [OW-1:0]    rw_base_q;
  logic [AW-1:0]    clr_q;
  logic             out_valid_q;
  bpa_pkg::rsp_t    out_q;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic [WORD_BITS-1:0] ok_vec, top_all, rmw_mask;
  logic [BW-1:0]    fb;
  logic             found;
  logic [OW-1:0]    hi_scan, lo_scan, lo_free, hi_free;
  logic             req_bad, rmw_last;
  logic [PRW-1:0]   quo_prod;
  logic [PW-1:0]    first_page;

  bpa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // request check
  always_comb begin
    logic [31:0] cnt32;
    logic [31:0] idx32;
    cnt32   = 32'(req_q.page_count);
    idx32   = 32'(req_q.page_index);
    req_bad = (cnt32 == 32'd0) || (cnt32 > 32'(MAX_RUN));
    if (req_q.cmd == bpa_pkg::CMD_FREE) begin
      if (idx32 < 32'(FIRST_MANAGED_PAGE)) begin
        req_bad = 1'b1;
      end else if (idx32 - 32'(FIRST_MANAGED_PAGE) + cnt32 > 32'(MANAGED_PAGES)) begin
        req_bad = 1'b1;
      end
    end
    lo_free = OW'(idx32 - 32'(FIRST_MANAGED_PAGE));
    hi_free = lo_free + OW'(req_q.page_count) - OW'(1);
  end

  // word scan: run ending at each bit, counting the carry from lower words
  always_comb begin
    logic win;
    int   n;
    int   lead;
    int   csum;
    n    = int'(req_q.page_count);
    win  = 1'b1;
    for (int b = 0; b < WORD_BITS; b++) begin
      win = 1'b1;
      for (int i = 0; i < WORD_BITS; i++) begin
        if (i <= b && i + n > b) begin
          win = win & ram_rdata[i];
        end
      end
      ok_vec[b] = win && (int'(carry_q) + b + 1 >= n);
    end
    fb = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (ok_vec[b]) begin
        fb = BW'(b);
      end
    end
    found = |ok_vec;
    for (int i = 0; i < WORD_BITS; i++) begin
      top_all[i] = ((ram_rdata >> i) == ({WORD_BITS{1'b1}} >> i));
    end
    lead = $countones(top_all);
    if (&ram_rdata) begin
      csum = int'(carry_q) + WORD_BITS;
    end else begin
      csum = lead;
    end
    carry_d = (csum > n) ? req_q.page_count : NW'(csum);
    hi_scan = sbase_q + OW'(fb);
    lo_scan = hi_scan + OW'(1) - OW'(req_q.page_count);
  end

  // range mask for the word under read-modify-write
  always_comb begin
    int p;
    p = 0;
    for (int i = 0; i < WORD_BITS; i++) begin
      p = int'(rw_base_q) + i;
      rmw_mask[i] = (p >= int'(lo_q)) && (p <= int'(hi_q));
    end
    rmw_last = (int'(rw_base_q) + WORD_BITS > int'(hi_q));
  end

  // word index of the run start by reciprocal multiply
  assign quo_prod = PRW'(lo_q) * PRW'(RECIP);

  always_comb begin
    case (cmd_i.rd_sel)
      bpa_pkg::RD_ZERO: ram_raddr = '0;
      bpa_pkg::RD_SCAN: ram_raddr = (scan_q == LAST_WORD) ? '0 : scan_q + AW'(1);
      bpa_pkg::RD_QUO:  ram_raddr = quo_q;
      bpa_pkg::RD_RW:   ram_raddr = rw_word_q;
      default:          ram_raddr = '0;
    endcase
  end

  assign ram_we    = cmd_i.clr_wr | cmd_i.rmw_wr;
  assign ram_waddr = cmd_i.clr_wr ? clr_q : rw_word_q;
  assign ram_wdata = cmd_i.clr_wr ? '0 :
                     (req_q.cmd == bpa_pkg::CMD_FREE) ? (ram_rdata | rmw_mask) :
                                                        (ram_rdata & ~rmw_mask);

  assign first_page = ((cmd_i.out_status == bpa_pkg::ST_DONE) &&
                       (req_q.cmd == bpa_pkg::CMD_ALLOC)) ?
                      PW'(32'(FIRST_MANAGED_PAGE) + 32'(lo_q)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_req_i;
    end
    if (cmd_i.scan_start) begin
      carry_q <= '0;
      scan_q  <= '0;
      sbase_q <= '0;
    end else if (cmd_i.scan_step) begin
      carry_q <= carry_d;
      scan_q  <= scan_q + AW'(1);
      sbase_q <= sbase_q + WB_OW;
    end
    if (cmd_i.free_range) begin
      lo_q <= lo_free;
      hi_q <= hi_free;
    end else if (cmd_i.alloc_range) begin
      lo_q <= lo_scan;
      hi_q <= hi_scan;
    end
    if (cmd_i.div_start) begin
      quo_q <= AW'(quo_prod >> SH);
    end
    if (cmd_i.div_step) begin
      rem_q <= lo_q - OW'(32'(quo_q) * 32'(WORD_BITS));
    end
    if (cmd_i.rmw_init) begin
      rw_word_q <= quo_q;
      rw_base_q <= lo_q - rem_q;
    end else if (cmd_i.rmw_wr) begin
      rw_word_q <= rw_word_q + AW'(1);
      rw_base_q <= rw_base_q + WB_OW;
    end
    if (cmd_i.out_load) begin
      out_q.status     <= cmd_i.out_status;
      out_q.first_page <= first_page;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.clr_last   = (clr_q == LAST_WORD);
    sts_o.req_bad    = req_bad;
    sts_o.req_free   = (req_q.cmd == bpa_pkg::CMD_FREE);
    sts_o.scan_found = found;
    sts_o.scan_last  = (scan_q == LAST_WORD);
    sts_o.div_last   = 1'b1;
    sts_o.rmw_last   = rmw_last;
    sts_o.out_ready  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_no_page_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != bpa_pkg::ST_DONE) |-> (out_q.first_page == '0))
    else $error("failed request reports a page");

  a_div_rem_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rmw_init |-> (32'(rem_q) < 32'(WORD_BITS)) && (lo_q <= hi_q))
    else $error("word divide left a remainder of a word or more");

  a_rmw_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rmw_wr |-> (32'(rw_word_q) < 32'(MAP_WORDS)) && (rw_base_q <= hi_q))
    else $error("range update outside the run");

endmodule

@@ sv/bitmap_page_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_allocator : first-fit contiguous page allocator over a bitmap
//
//   channel  direction  handshake          payload
//   in       request    in_valid_i/stall   bpa_pkg::req_t  cmd, page_index, page_count
//   out      result     out_valid_o/stall  bpa_pkg::rsp_t  status, first_page
//
// one request at a time; the result sits in an output register
// after reset a clearing pass over all MAP_WORDS words (128 words by default) holds in_stall_o high
// allocate: check, word scan, word divide, then a read and a write per word touched
// free: check, divide, read and write per word; bad request skips to result; then idle
// the map ram read port sets the pace, one word per cycle in the scan
// a stalled result holds the next request in its final step
// ----------------------------------------------------------------------------
module bitmap_page_allocator #(
  parameter int MANAGED_PAGES      = 4096,
  parameter int WORD_BITS          = 32,
  parameter int FIRST_MANAGED_PAGE = 1024,
  parameter int MAX_RUN            = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bpa_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bpa_pkg::rsp_t out_rsp_o
);

  bpa_pkg::ctl_cmd_t ctl_cmd;
  bpa_pkg::ctl_sts_t ctl_sts;

  bpa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (ctl_sts),
    .cmd_o     (ctl_cmd)
  );

  bpa_dp #(
    .MANAGED_PAGES     (MANAGED_PAGES),
    .WORD_BITS         (WORD_BITS),
    .FIRST_MANAGED_PAGE(FIRST_MANAGED_PAGE),
    .MAX_RUN           (MAX_RUN)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req_i),
    .cmd_i      (ctl_cmd),
    .sts_o      (ctl_sts),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_rsp_o  (out_rsp_o)
  );

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken before the first finished");

endmodule

@@ sim/bitmap_page_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator_tb : self-checking bench for the bitmap page allocator
// sends allocate and free requests in random bursts while the result side
// stalls, keeps its own page map to work out every result and compares
// status and first page of each result in order
// ----------------------------------------------------------------------------
module bitmap_page_allocator_tb;

  localparam int MANAGED_PAGES = 4096;
  localparam int FIRST_PAGE    = 1024;
  localparam int MAX_RUN       = 256;
  localparam int DRAIN_CYCLES  = 200;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int MAX_REPORTS   = 10;
  localparam int PW            = bpa_pkg::PAGE_W;
  localparam int CW            = bpa_pkg::CNT_W;

  typedef struct {
    int unsigned page;
    int unsigned count;
  } run_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  bpa_pkg::req_t in_req_i;
  logic          out_valid_o;
  logic          out_stall_i;
  bpa_pkg::rsp_t out_rsp_o;

  bit            page_is_free [MANAGED_PAGES];
  bpa_pkg::rsp_t awaited_rsp [$];
  run_t          live_runs [$];

  int error_count = 0;
  int report_count = 0;
  int cycle_count = 0;
  int gap_max = 0;
  int burst_max = 1;
  int burst_left = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  bitmap_page_allocator #(
    .MANAGED_PAGES     (MANAGED_PAGES),
    .WORD_BITS         (32),
    .FIRST_MANAGED_PAGE(FIRST_PAGE),
    .MAX_RUN           (MAX_RUN)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side stall pattern, with a long hold on request
  initial begin : rsp_stall
    int stall_left;
    stall_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(0, 5);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : rsp_check
    bpa_pkg::rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_rsp.size() == 0) begin
        error_count++;
        if (report_count < MAX_REPORTS) begin
          report_count++;
          $display("%0t: result with none awaited: status %0d first_page %0d", $realtime,
                   out_rsp_o.status, out_rsp_o.first_page);
        end
      end else begin
        want = awaited_rsp.pop_front();
        if (out_rsp_o.status !== want.status || out_rsp_o.first_page !== want.first_page) begin
          error_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%0t: mismatch: status exp %0d got %0d, first_page exp %0d got %0d",
                     $realtime, want.status, out_rsp_o.status, want.first_page,
                     out_rsp_o.first_page);
          end
        end
      end
    end
  end

  // first-fit allocate or range free on the bench's own page map
  function automatic bpa_pkg::rsp_t apply_request(bpa_pkg::req_t r);
    bpa_pkg::rsp_t rsp;
    int   n;
    int   idx;
    int   run;
    int   at;
    rsp.status = bpa_pkg::ST_DONE;
    rsp.first_page = '0;
    n = r.page_count;
    idx = r.page_index;
    at = -1;
    if (n == 0 || n > MAX_RUN) begin
      rsp.status = bpa_pkg::ST_BAD;
    end else if (r.cmd == bpa_pkg::CMD_ALLOC) begin
      run = 0;
      for (int k = 0; k < MANAGED_PAGES && at < 0; k++) begin
        run = page_is_free[k] ? run + 1 : 0;
        if (run == n) at = k + 1 - n;
      end
      if (at < 0) begin
        rsp.status = bpa_pkg::ST_NO_RUN;
      end else begin
        for (int k = at; k < at + n; k++) page_is_free[k] = 1'b0;
        rsp.first_page = PW'(FIRST_PAGE + at);
        live_runs.push_back('{page: FIRST_PAGE + at, count: n});
      end
    end else if (idx < FIRST_PAGE || idx - FIRST_PAGE + n > MANAGED_PAGES) begin
      rsp.status = bpa_pkg::ST_BAD;
    end else begin
      for (int k = idx - FIRST_PAGE; k < idx - FIRST_PAGE + n; k++) page_is_free[k] = 1'b1;
    end
    return rsp;
  endfunction

  function automatic bpa_pkg::req_t build_req(bpa_pkg::cmd_e cmd, int unsigned idx,
                                              int unsigned cnt);
    bpa_pkg::req_t r;
    r.cmd = cmd;
    r.page_index = PW'(idx);
    r.page_count = CW'(cnt);
    return r;
  endfunction

  function automatic bpa_pkg::req_t random_request();
    bpa_pkg::req_t r;
    int   n;
    int   pick;
    int   i;
    run_t victim;
    pick = $urandom_range(0, 99);
    if (pick < 70) n = $urandom_range(1, 16);
    else if (pick < 95) n = $urandom_range(17, 64);
    else n = $urandom_range(65, MAX_RUN);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      r.cmd = bpa_pkg::cmd_e'($urandom_range(0, 1));
      r.page_index = PW'($urandom);
      r.page_count = CW'($urandom);
    end else if (pick < 55) begin
      r = build_req(bpa_pkg::CMD_ALLOC, $urandom, n);
    end else if (live_runs.size() != 0 && pick < 85) begin
      i = $urandom_range(0, live_runs.size() - 1);
      victim = live_runs[i];
      live_runs.delete(i);
      r = build_req(bpa_pkg::CMD_FREE, victim.page, victim.count);
    end else begin
      r = build_req(bpa_pkg::CMD_FREE, FIRST_PAGE + $urandom_range(0, MANAGED_PAGES - n), n);
    end
    return r;
  endfunction

  task automatic send_request(input bpa_pkg::req_t r);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, burst_max);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    awaited_rsp.push_back(apply_request(r));
  endtask

  task automatic wait_drain(input int extra);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_request(random_request());
  endtask

  task automatic test_edge_cases();
    gap_max = 4;
    burst_max = 4;
    stall_pct = 20;
    send_request(build_req(bpa_pkg::CMD_ALLOC, 0, 1));
    send_request(build_req(bpa_pkg::CMD_ALLOC, 0, 0));
    send_request(build_req(bpa_pkg::CMD_FREE, FIRST_PAGE, 0));
    send_request(build_req(bpa_pkg::CMD_ALLOC, 'hFFFFF, MAX_RUN + 1));
    send_request(build_req(bpa_pkg::CMD_ALLOC, 0, 511));
    send_request(build_req(bpa_pkg::CMD_FREE, FIRST_PAGE, MAX_RUN + 1));
    send_request(build_req(bpa_pkg::CMD_FREE, FIRST_PAGE - 1, 1));
    send_request(build_req(bpa_pkg::CMD_FREE, 0, 1));
    send_request(build_req(bpa_pkg::CMD_FREE, 'hFFFFF, MAX_RUN));
    send_request(build_req(bpa_pkg::CMD_FREE, FIRST_PAGE + MANAGED_PAGES - 1, 2));
    send_request(build_req(bpa_pkg::CMD_FREE, FIRST_PAGE + MANAGED_PAGES - MAX_RUN, MAX_RUN));
    send_request(build_req(bpa_pkg::CMD_FREE, FIRST_PAGE, MAX_RUN));
    send_request(build_req(bpa_pkg::CMD_FREE, FIRST_PAGE, 1));
    send_request(build_req(bpa_pkg::CMD_ALLOC, 0, MAX_RUN));
    send_request(build_req(bpa_pkg::CMD_ALLOC, 0, 1));
    // run across a word boundary
    send_request(build_req(bpa_pkg::CMD_FREE, FIRST_PAGE + 30, 4));
    send_request(build_req(bpa_pkg::CMD_ALLOC, 0, 4));
    send_request(build_req(bpa_pkg::CMD_ALLOC, 0, MAX_RUN));
    send_request(build_req(bpa_pkg::CMD_ALLOC, 0, MAX_RUN - 1));
    send_request(build_req(bpa_pkg::CMD_ALLOC, 0, 1));
    wait_drain(DRAIN_CYCLES);
  endtask

  task automatic test_fill_map();
    live_runs.delete();
    for (int p = 0; p < MANAGED_PAGES; p += MAX_RUN) begin
      send_request(build_req(bpa_pkg::CMD_FREE, FIRST_PAGE + p, MAX_RUN));
    end
    wait_drain(0);
  endtask

  task automatic test_random_traffic();
    gap_max = 8;
    burst_max = 6;
    stall_pct = 30;
    send_random(380);
    wait_drain(0);
  endtask

  task automatic test_output_hold();
    gap_max = 0;
    burst_max = 1;
    stall_pct = 0;
    hold_cycles = 400;
    send_random(20);
    // sender pauses until every result is back
    wait_drain(0);
  endtask

  task automatic test_full_rate();
    gap_max = 0;
    burst_max = 1;
    stall_pct = 0;
    send_random(100);
    wait_drain(0);
  endtask

  task automatic test_heavy_stall();
    gap_max = 20;
    burst_max = 3;
    stall_pct = 70;
    send_random(100);
    wait_drain(DRAIN_CYCLES);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_edge_cases();
    test_fill_map();
    test_random_traffic();
    test_output_hold();
    test_full_rate();
    test_heavy_stall();
    if (error_count == 0 && awaited_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
